>>> sv/cbm_pkg.sv
// Shared types and address map constants for the dual-window cartridge bank mapper.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int AddrW    = 16;
  localparam int DataW    = 8;
  localparam int BankW    = 8;
  localparam int MemAddrW = 21;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_t;

  localparam logic [AddrW-1:0] MaskQuarter  = 16'hc000;
  localparam logic [AddrW-1:0] MaskEighth   = 16'he000;
  localparam logic [AddrW-1:0] MaskSixteen  = 16'hf000;
  localparam logic [AddrW-1:0] MaskCtrlFine = 16'hfc00;
  localparam logic [AddrW-1:0] MaskCtrlRom  = 16'hf800;

  localparam logic [AddrW-1:0] CtrlRamEnable = 16'h0000;
  localparam logic [AddrW-1:0] CtrlRamLow    = 16'h0400;
  localparam logic [AddrW-1:0] CtrlRamHigh   = 16'h0800;
  localparam logic [AddrW-1:0] CtrlRomLow    = 16'h2000;
  localparam logic [AddrW-1:0] CtrlRomHigh   = 16'h3000;

  localparam logic [AddrW-1:0] BaseFixedRom = 16'h0000;
  localparam logic [AddrW-1:0] BaseRomLow   = 16'h4000;
  localparam logic [AddrW-1:0] BaseRomHigh  = 16'h6000;
  localparam logic [AddrW-1:0] BaseRamLow   = 16'ha000;
  localparam logic [AddrW-1:0] BaseRamHigh  = 16'hb000;

  localparam logic [3:0] RamEnableKey = 4'ha;

  // Current contents of the bank registers.
  typedef struct packed {
    logic [BankW-1:0] rom_low;
    logic [BankW-1:0] rom_high;
    logic             ram_enabled;
    logic [BankW-1:0] ram_low;
    logic [BankW-1:0] ram_high;
  } cbm_banks_t;

  // Register update requested by a control write.
  typedef struct packed {
    logic             ram_enable_we;
    logic             ram_enable_val;
    logic             ram_low_we;
    logic             ram_high_we;
    logic             rom_low_we;
    logic             rom_high_we;
    logic [DataW-1:0] data;
  } cbm_reg_write_t;

endpackage

>>> sv/cbm_bank_regs.sv
// Bank and RAM enable registers of the cartridge mapper.
// Depends on cbm_pkg for the register and update structs.
`timescale 1ns / 1ps

module cbm_bank_regs
  import cbm_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           update,
  input  cbm_reg_write_t wr,
  output cbm_banks_t     banks
);

  always_ff @(posedge clk) begin
    if (rst) begin
      banks <= '0;
    end else if (update) begin
      if (wr.ram_enable_we) banks.ram_enabled <= wr.ram_enable_val;
      if (wr.ram_low_we)    banks.ram_low     <= wr.data;
      if (wr.ram_high_we)   banks.ram_high    <= wr.data;
      if (wr.rom_low_we)    banks.rom_low     <= wr.data;
      if (wr.rom_high_we)   banks.rom_high    <= wr.data;
    end
  end

endmodule

>>> sv/cbm_decode.sv
// Combinational address decode and bank translation for one bus access.
// Depends on cbm_pkg for the address map, target codes and structs.
`timescale 1ns / 1ps

module cbm_decode
  import cbm_pkg::*;
(
  input  logic                operation,
  input  logic [AddrW-1:0]    address,
  input  logic [DataW-1:0]    write_data,
  input  cbm_banks_t          banks,
  output target_t             target,
  output logic [MemAddrW-1:0] mem_address,
  output logic                mem_write,
  output logic [DataW-1:0]    mem_data,
  output cbm_reg_write_t      wr
);

  logic in_ram_low;
  logic in_ram_high;

  assign in_ram_low  = ((address & MaskSixteen) == BaseRamLow) && banks.ram_enabled;
  assign in_ram_high = ((address & MaskSixteen) == BaseRamHigh) && banks.ram_enabled;

  always_comb begin
    target         = TGT_NONE;
    mem_address    = '0;
    mem_write      = 1'b0;
    mem_data       = '0;
    wr             = '0;
    wr.data        = write_data;
    wr.ram_enable_val = (write_data[3:0] == RamEnableKey);

    if (operation) begin
      // Control ranges take priority and never reach memory.
      if ((address & MaskCtrlFine) == CtrlRamEnable) begin
        wr.ram_enable_we = 1'b1;
      end else if ((address & MaskCtrlFine) == CtrlRamLow) begin
        wr.ram_low_we = 1'b1;
      end else if ((address & MaskCtrlFine) == CtrlRamHigh) begin
        wr.ram_high_we = 1'b1;
      end else if ((address & MaskCtrlRom) == CtrlRomLow) begin
        wr.rom_low_we = 1'b1;
      end else if ((address & MaskCtrlRom) == CtrlRomHigh) begin
        wr.rom_high_we = 1'b1;
      end else if (in_ram_low) begin
        target      = TGT_RAM;
        mem_address = {1'b0, banks.ram_low, address[11:0]};
        mem_write   = 1'b1;
        mem_data    = write_data;
      end else if (in_ram_high) begin
        target      = TGT_RAM;
        mem_address = {1'b0, banks.ram_high, address[11:0]};
        mem_write   = 1'b1;
        mem_data    = write_data;
      end
    end else begin
      if ((address & MaskQuarter) == BaseFixedRom) begin
        target      = TGT_ROM;
        mem_address = {7'd0, address[13:0]};
      end else if ((address & MaskEighth) == BaseRomLow) begin
        target      = TGT_ROM;
        mem_address = {banks.rom_low, address[12:0]};
      end else if ((address & MaskEighth) == BaseRomHigh) begin
        target      = TGT_ROM;
        mem_address = {banks.rom_high, address[12:0]};
      end else if (in_ram_low) begin
        target      = TGT_RAM;
        mem_address = {1'b0, banks.ram_low, address[11:0]};
      end else if (in_ram_high) begin
        target      = TGT_RAM;
        mem_address = {1'b0, banks.ram_high, address[11:0]};
      end
    end
  end

endmodule

>>> sv/cartridge_bank_mapper_dual_window.sv
// Dual-window cartridge bank mapper: one bus access in, one translated request out.
// The input register loads at acceptance; decode and bank lookup feed the result register
// when the input register advances, which a stalled output holds off. Throughput is one
// transaction per cycle unless the output stalls; bank registers update on the edge that
// registers the control write's result. Synchronous active-high reset clears the bank
// registers, RAM enable and both stages. Depends on cbm_pkg, cbm_bank_regs and cbm_decode.
`timescale 1ns / 1ps

module cartridge_bank_mapper_dual_window
  import cbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [AddrW-1:0]    address,
  input  logic [DataW-1:0]    write_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          target,
  output logic [MemAddrW-1:0] mem_address,
  output logic                mem_write,
  output logic [DataW-1:0]    mem_data
);

  logic             s1_valid;
  logic             s1_operation;
  logic [AddrW-1:0] s1_address;
  logic [DataW-1:0] s1_write_data;
  logic             advance;

  cbm_banks_t          banks;
  cbm_reg_write_t      wr;
  target_t             dec_target;
  logic [MemAddrW-1:0] dec_mem_address;
  logic                dec_mem_write;
  logic [DataW-1:0]    dec_mem_data;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_operation  <= operation;
      s1_address    <= address;
      s1_write_data <= write_data;
    end
  end

  cbm_decode u_decode (
    .operation   (s1_operation),
    .address     (s1_address),
    .write_data  (s1_write_data),
    .banks       (banks),
    .target      (dec_target),
    .mem_address (dec_mem_address),
    .mem_write   (dec_mem_write),
    .mem_data    (dec_mem_data),
    .wr          (wr)
  );

  cbm_bank_regs u_bank_regs (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .wr     (wr),
    .banks  (banks)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      target      <= dec_target;
      mem_address <= dec_mem_address;
      mem_write   <= dec_mem_write;
      mem_data    <= dec_mem_data;
    end
  end

`ifndef ASSERT_OFF
  // A result with no target carries an all-zero request.
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && target == TGT_NONE) |-> (mem_address == '0 && !mem_write && mem_data == '0))
    else $error("untargeted result carries a nonzero request");

  // Only RAM accesses may write memory.
  a_write_only_ram: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mem_write) |-> (target == TGT_RAM))
    else $error("memory write on a non-RAM target");

  // An item held in the input register is never dropped while the output stalls.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_address) && $stable(s1_operation)))
    else $error("input register lost a stalled transaction");

  // Bank registers only change when a transaction moves into the result register.
  a_banks_change_on_advance: assert property (@(posedge clk) disable iff (rst)
    (!advance) |=> $stable(banks))
    else $error("bank registers changed without a transaction");
`endif

endmodule

>>> dv/tb_cartridge_bank_mapper_dual_window.sv
// Self-checking testbench for cartridge_bank_mapper_dual_window: directed table, then weighted
// random bus accesses, checked against the table or an in-bench model of the bank registers.
// Depends on cbm_pkg and the cartridge_bank_mapper_dual_window RTL.
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper_dual_window;
  import cbm_pkg::*;

  localparam int NumDirected = 28;
  localparam int NumRandom   = 1200;
  localparam int CycleLimit  = 400000;
  localparam int HoldStart   = 300;
  localparam int HoldLen     = 200;
  localparam int DrainCycles = 10;
  localparam int MaxReports  = 10;

  typedef struct packed {
    target_t               tgt;
    logic [MemAddrW-1:0]   maddr;
    logic                  mwr;
    logic [DataW-1:0]      mdata;
  } bus_request_t;

  // One directed access; when known is set the typed request is the expectation.
  typedef struct packed {
    logic                  op;
    logic [AddrW-1:0]      addr;
    logic [DataW-1:0]      wdata;
    logic                  known;
    bus_request_t          req;
  } access_row_t;

  localparam access_row_t DirectedRows [0:NumDirected-1] = '{
    '{1'b0, 16'h0000, 8'h00, 1'b1, '{TGT_ROM,  21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'h3fff, 8'hff, 1'b1, '{TGT_ROM,  21'h003fff, 1'b0, 8'h00}},
    '{1'b0, 16'h4000, 8'h00, 1'b1, '{TGT_ROM,  21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'h7fff, 8'h00, 1'b1, '{TGT_ROM,  21'h001fff, 1'b0, 8'h00}},
    '{1'b0, 16'ha000, 8'h00, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'hb123, 8'h55, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'h8000, 8'h00, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'hffff, 8'hff, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'h2000, 8'hff, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'h37ff, 8'h80, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'h5fff, 8'h00, 1'b1, '{TGT_ROM,  21'h1fffff, 1'b0, 8'h00}},
    '{1'b0, 16'h6000, 8'h00, 1'b1, '{TGT_ROM,  21'h100000, 1'b0, 8'h00}},
    '{1'b1, 16'h03ff, 8'h5a, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'h0400, 8'hff, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'h0bff, 8'h01, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'hafff, 8'h00, 1'b1, '{TGT_RAM,  21'h0fffff, 1'b0, 8'h00}},
    '{1'b1, 16'hb000, 8'ha5, 1'b1, '{TGT_RAM,  21'h001000, 1'b1, 8'ha5}},
    '{1'b1, 16'ha001, 8'h00, 1'b1, '{TGT_RAM,  21'h0ff001, 1'b1, 8'h00}},
    '{1'b1, 16'h1000, 8'hff, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'h4000, 8'h12, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'h0400, 8'h00, 1'b1, '{TGT_ROM,  21'h000400, 1'b0, 8'h00}},
    '{1'b1, 16'h0000, 8'ha0, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'hb000, 8'h00, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'h0000, 8'hfa, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'hbfff, 8'h00, 1'b1, '{TGT_RAM,  21'h001fff, 1'b0, 8'h00}},
    '{1'b1, 16'hc000, 8'h77, 1'b1, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b0, 16'h6001, 8'hff, 1'b0, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}},
    '{1'b1, 16'h2fff, 8'h3c, 1'b0, '{TGT_NONE, 21'h000000, 1'b0, 8'h00}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                operation = 1'b0;
  logic [AddrW-1:0]    address = '0;
  logic [DataW-1:0]    write_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          target;
  logic [MemAddrW-1:0] mem_address;
  logic                mem_write;
  logic [DataW-1:0]    mem_data;

  // Travels with the payload so the acceptance monitor knows what to expect.
  logic                row_known = 1'b0;
  bus_request_t        row_request = '0;

  // Model copy of the bank registers.
  logic [BankW-1:0]    model_rom_low;
  logic [BankW-1:0]    model_rom_high;
  logic                model_ram_enabled;
  logic [BankW-1:0]    model_ram_low;
  logic [BankW-1:0]    model_ram_high;

  bus_request_t        pending_requests [$];
  int                  fail_count = 0;
  int                  cycle_count = 0;
  int                  burst_left = 0;
  bit                  sender_done = 1'b0;

  cartridge_bank_mapper_dual_window u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .address     (address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .target      (target),
    .mem_address (mem_address),
    .mem_write   (mem_write),
    .mem_data    (mem_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one access to the model bank registers and returns the translated request.
  function automatic bus_request_t translate_access(logic op, logic [AddrW-1:0] a,
                                                    logic [DataW-1:0] d);
    bus_request_t req;
    req = '{TGT_NONE, '0, 1'b0, '0};
    if (op) begin
      if ((a & MaskCtrlFine) == CtrlRamEnable) begin
        model_ram_enabled = (d[3:0] == RamEnableKey);
      end else if ((a & MaskCtrlFine) == CtrlRamLow) begin
        model_ram_low = d;
      end else if ((a & MaskCtrlFine) == CtrlRamHigh) begin
        model_ram_high = d;
      end else if ((a & MaskCtrlRom) == CtrlRomLow) begin
        model_rom_low = d;
      end else if ((a & MaskCtrlRom) == CtrlRomHigh) begin
        model_rom_high = d;
      end else if ((a & MaskSixteen) == BaseRamLow && model_ram_enabled) begin
        req = '{TGT_RAM, {1'b0, model_ram_low, a[11:0]}, 1'b1, d};
      end else if ((a & MaskSixteen) == BaseRamHigh && model_ram_enabled) begin
        req = '{TGT_RAM, {1'b0, model_ram_high, a[11:0]}, 1'b1, d};
      end
    end else begin
      if ((a & MaskQuarter) == BaseFixedRom) begin
        req = '{TGT_ROM, {7'd0, a[13:0]}, 1'b0, '0};
      end else if ((a & MaskEighth) == BaseRomLow) begin
        req = '{TGT_ROM, {model_rom_low, a[12:0]}, 1'b0, '0};
      end else if ((a & MaskEighth) == BaseRomHigh) begin
        req = '{TGT_ROM, {model_rom_high, a[12:0]}, 1'b0, '0};
      end else if ((a & MaskSixteen) == BaseRamLow && model_ram_enabled) begin
        req = '{TGT_RAM, {1'b0, model_ram_low, a[11:0]}, 1'b0, '0};
      end else if ((a & MaskSixteen) == BaseRamHigh && model_ram_enabled) begin
        req = '{TGT_RAM, {1'b0, model_ram_high, a[11:0]}, 1'b0, '0};
      end
    end
    return req;
  endfunction

  // Offers one access, sometimes with an idle gap first when the current burst has run out.
  task automatic send_access(logic op, logic [AddrW-1:0] a, logic [DataW-1:0] d,
                             logic known, bus_request_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    operation   <= op;
    address     <= a;
    write_data  <= d;
    row_known   <= known;
    row_request <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Every accepted transaction updates the model; its expectation joins the queue.
  always @(posedge clk) begin
    bus_request_t req;
    if (rst) begin
      model_rom_low     = '0;
      model_rom_high    = '0;
      model_ram_enabled = 1'b0;
      model_ram_low     = '0;
      model_ram_high    = '0;
    end else if (in_valid && in_ready) begin
      req = translate_access(operation, address, write_data);
      pending_requests.push_back(row_known ? row_request : req);
    end
  end

  always @(posedge clk) begin
    bus_request_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_requests.size() == 0) begin
        if (fail_count < MaxReports) begin
          $display("%0t: result with nothing expected: target %0d addr %06h wr %0b data %02h",
                   $realtime, target, mem_address, mem_write, mem_data);
        end
        fail_count++;
      end else begin
        want = pending_requests.pop_front();
        if (target != want.tgt || mem_address != want.maddr ||
            mem_write != want.mwr || mem_data != want.mdata) begin
          if (fail_count < MaxReports) begin
            $display("%0t: mismatch: target %0d/%0d addr %06h/%06h wr %0b/%0b data %02h/%02h",
                     $realtime, want.tgt, target, want.maddr, mem_address,
                     want.mwr, mem_write, want.mdata, mem_data);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: switches between stall patterns, with one long hold-off to back up the block.
  initial begin
    int mode;
    int mode_left;
    int recv_cycles;
    mode = 0;
    mode_left = 0;
    recv_cycles = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (recv_cycles >= HoldStart && recv_cycles < HoldStart + HoldLen) begin
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (recv_cycles % 3 != 0);
        endcase
      end
      recv_cycles++;
      @(posedge clk);
    end
  end

  // Sender: directed table first, then weighted random accesses.
  initial begin
    logic             op;
    logic [AddrW-1:0] a;
    logic [DataW-1:0] d;
    int               pick;
    @(posedge clk);
    while (rst) @(posedge clk);
    for (int i = 0; i < NumDirected; i++) begin
      send_access(DirectedRows[i].op, DirectedRows[i].addr, DirectedRows[i].wdata,
                  DirectedRows[i].known, DirectedRows[i].req);
    end
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 99);
      op   = 1'($urandom_range(0, 1));
      a    = AddrW'($urandom);
      d    = DataW'($urandom);
      if (pick < 10) begin
        // RAM enable writes, mostly with the enable key so RAM spends time switched on.
        op = 1'b1;
        a  = {6'd0, a[9:0]};
        if ($urandom_range(0, 9) < 7) d[3:0] = RamEnableKey;
      end else if (pick < 20) begin
        op = 1'b1;
        case ($urandom_range(0, 3))
          0: a = CtrlRamLow  | {6'd0, a[9:0]};
          1: a = CtrlRamHigh | {6'd0, a[9:0]};
          2: a = CtrlRomLow  | {5'd0, a[10:0]};
          default: a = CtrlRomHigh | {5'd0, a[10:0]};
        endcase
      end else if (pick < 45) begin
        a = BaseRamLow | {3'd0, a[12:0]};
      end else if (pick < 70) begin
        op = ($urandom_range(0, 7) == 0);
        a  = {1'b0, a[14:0]};
      end else if (pick < 85) begin
        // Fully random access.
      end else begin
        a = $urandom_range(0, 1) ? {3'b100, a[12:0]} : (MaskQuarter | a);
      end
      send_access(op, a, d, 1'b0, '0);
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!sender_done) @(posedge clk);
    // Let the last accepted transaction reach the queue first.
    @(posedge clk);
    while (pending_requests.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending_requests.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/cbm_pkg.sv
sv/cbm_bank_regs.sv
sv/cbm_decode.sv
sv/cartridge_bank_mapper_dual_window.sv
dv/tb_cartridge_bank_mapper_dual_window.sv
